>>> rtl/radix_digit_emitter_defines.svh
// ----------------------------------------------------------------------------
// Radix digit emitter assertion macros
// Shared concurrent assertion helpers for the radix digit emitter RTL.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_EMITTER_DEFINES_SVH
`define RADIX_DIGIT_EMITTER_DEFINES_SVH

// cons must hold in the same cycle as ante
`define RDE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define RDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg
// Types and constants shared by the radix digit emitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rde_pkg;

    localparam int VALUE_W = 64;
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0]  ASCII_ALPHA = 7'd55;
    localparam logic [RADIX_W-1:0] DEC_LIMIT   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
        logic              bad_radix;
    } out_item_t;

    typedef enum logic [1:0] {
        CLS_NUM,
        CLS_ZERO,
        CLS_BAD
    } cls_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        cls_t               cls;
    } q_item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SINGLE,
        BK_DIV,
        BK_WR,
        BK_RD,
        BK_EMIT
    } back_state_t;

endpackage

`default_nettype wire

>>> rtl/rde_ram.sv
// ----------------------------------------------------------------------------
// rde_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/rde_fifo.sv
// ----------------------------------------------------------------------------
// rde_fifo
// Two entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire rde_pkg::q_item_t push_item,
    input  wire logic             pop,
    output rde_pkg::q_item_t      head,
    output logic                  full,
    output logic                  empty
);

    import rde_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    q_item_t         entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rde_front.sv
// ----------------------------------------------------------------------------
// rde_front
// Accepts input items, masks the value and classifies radix and zero cases.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_front #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rde_pkg::in_item_t in_item,
    input  wire logic              q_full,
    output logic                   push,
    output rde_pkg::q_item_t       push_item
);

    import rde_pkg::*;

    localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);

    logic [VALUE_W-1:0] masked;
    logic               radix_ok;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;
    assign masked   = in_item.value & VALUE_MASK;
    assign radix_ok = (in_item.radix >= RADIX_MIN) && (in_item.radix <= RADIX_MAX);

    always_comb
    begin
        push_item.value = masked;
        push_item.radix = in_item.radix;
        priority if (!radix_ok)
        begin
            push_item.cls = CLS_BAD;
        end
        else if (masked == '0)
        begin
            push_item.cls = CLS_ZERO;
        end
        else
        begin
            push_item.cls = CLS_NUM;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rde_back.sv
// ----------------------------------------------------------------------------
// rde_back
// Divides by the radix one quotient bit per cycle, buffers the digits and
// emits them most significant first through an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "radix_digit_emitter_defines.svh"

module rde_back #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rde_pkg::q_item_t head,
    input  wire logic             q_empty,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output rde_pkg::out_item_t    out_item
);

    import rde_pkg::*;

    localparam int AW = $clog2(VALUE_BITS);

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [VALUE_BITS-1:0]  q_reg;
    logic [VALUE_BITS-1:0]  q_next;
    logic [RADIX_W-1:0]     rem_reg;
    logic [RADIX_W-1:0]     rem_next;
    logic [RADIX_W-1:0]     radix_reg;
    logic [RADIX_W-1:0]     radix_next;
    logic                   bad_reg;
    logic                   bad_next;
    logic [AW-1:0]          step_reg;
    logic [AW-1:0]          step_next;
    logic [AW-1:0]          dcnt_reg;
    logic [AW-1:0]          dcnt_next;
    logic [AW-1:0]          idx_reg;
    logic [AW-1:0]          idx_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_item_t              out_item_reg;
    out_item_t              out_item_next;

    logic [RADIX_W:0]       rem_sh;
    logic [RADIX_W:0]       rem_diff;
    logic                   rem_ge;
    logic                   out_load;
    logic                   ram_we;
    logic [CHAR_W-1:0]      digit_ascii;
    logic [CHAR_W-1:0]      ram_rdata;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_load  = !out_valid_reg || out_ready;

    assign rem_sh   = {rem_reg, q_reg[VALUE_BITS-1]};
    assign rem_diff = rem_sh - {1'b0, radix_reg};
    assign rem_ge   = (rem_sh >= {1'b0, radix_reg});

    assign digit_ascii = (rem_reg < DEC_LIMIT) ? (CHAR_W'(rem_reg) + ASCII_ZERO)
                                               : (CHAR_W'(rem_reg) + ASCII_ALPHA);

    rde_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (VALUE_BITS)
    ) u_digit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (dcnt_reg),
        .wdata (digit_ascii),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        radix_next     = radix_reg;
        bad_next       = bad_reg;
        step_next      = step_reg;
        dcnt_next      = dcnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    q_next     = head.value[VALUE_BITS-1:0];
                    radix_next = head.radix;
                    bad_next   = (head.cls == CLS_BAD);
                    rem_next   = '0;
                    step_next  = '0;
                    dcnt_next  = '0;
                    state_next = (head.cls == CLS_NUM) ? BK_DIV : BK_SINGLE;
                end
            end
            BK_SINGLE:
            begin
                if (out_load)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.digit_char = bad_reg ? '0 : ASCII_ZERO;
                    out_item_next.last       = 1'b1;
                    out_item_next.bad_radix  = bad_reg;
                    state_next               = BK_IDLE;
                end
            end
            BK_DIV:
            begin
                q_next    = {q_reg[VALUE_BITS-2:0], rem_ge};
                rem_next  = rem_ge ? rem_diff[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == AW'(VALUE_BITS - 1))
                begin
                    state_next = BK_WR;
                end
            end
            BK_WR:
            begin
                ram_we = 1'b1;
                if (q_reg == '0)
                begin
                    idx_next   = dcnt_reg;
                    state_next = BK_RD;
                end
                else
                begin
                    dcnt_next  = dcnt_reg + 1'b1;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = BK_DIV;
                end
            end
            BK_RD:
            begin
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.digit_char = ram_rdata;
                    out_item_next.last       = (idx_reg == '0);
                    out_item_next.bad_radix  = 1'b0;
                    if (idx_reg == '0)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = BK_RD;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            dcnt_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            dcnt_reg      <= dcnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        rem_reg      <= rem_next;
        radix_reg    <= radix_next;
        bad_reg      <= bad_next;
        out_item_reg <= out_item_next;
    end

    `RDE_ASSERT_IMPLIES(a_pop_idle, clk, rst_n, pop, (state_reg == BK_IDLE) && !q_empty,
        "queue popped outside idle or while empty")
    `RDE_ASSERT_IMPLIES(a_bad_form, clk, rst_n, out_valid_reg && out_item_reg.bad_radix,
        out_item_reg.last && (out_item_reg.digit_char == '0), "malformed radix error item")
    `RDE_ASSERT_IMPLIES(a_digit_room, clk, rst_n, (state_reg == BK_WR) && (q_reg != '0),
        dcnt_reg != AW'(VALUE_BITS - 1), "digit buffer overrun")
    `RDE_ASSERT_NEXT(a_emit_follows_rd, clk, rst_n, state_reg == BK_RD,
        state_reg == BK_EMIT, "emit did not follow buffer read")

endmodule

`default_nettype wire

>>> rtl/radix_digit_emitter.sv
// Flow: an accepted item enters the queue, then the bit-serial radix divider
// produces its digits one by one, and they are read back out of the digit RAM.
// The queue takes new items while the back end still works on one; zero and
// bad radix items skip the divider and give a single output item.
// Reset: asynchronous, active low; clears queue and control, no RAM clearing.
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Converts an unsigned value into ASCII digits of a radix from 2 to 36.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_emitter #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rde_pkg::in_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rde_pkg::out_item_t     out_item
);

    import rde_pkg::*;

    logic    q_full;
    logic    q_empty;
    logic    push;
    logic    pop;
    q_item_t push_item;
    q_item_t head;

    rde_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    rde_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    rde_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

>>> sim/radix_digit_emitter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter_test
// Drives values and radixes into the digit emitter and checks every ASCII
// digit that comes back against table results or digits from repeated division.
// A directed table covers the zero value, bad radixes and the extreme values
// and bases. Random items follow under several idle and stall patterns. A
// long receiver hold-off fills the input queue until the block stalls.
// ----------------------------------------------------------------------------
module radix_digit_emitter_test;
    import rde_pkg::*;

    localparam int VALUE_BITS = 64;
    localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_BITS{1'b1}};
    localparam logic [VALUE_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam out_item_t BAD_RESULT = '{7'd0, 1'b1, 1'b1};
    localparam out_item_t ZERO_RESULT = '{ASCII_ZERO, 1'b1, 1'b0};
    localparam out_item_t NO_RESULT = '0;
    localparam int NUM_ROWS = 23;

    typedef struct packed {
        in_item_t  stim;
        logic      typed;
        out_item_t result;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{'{64'd0, 6'd10}, 1'b1, ZERO_RESULT},
        '{'{64'd0, 6'd2}, 1'b1, ZERO_RESULT},
        '{'{64'd0, 6'd36}, 1'b1, ZERO_RESULT},
        '{'{64'd12345, 6'd0}, 1'b1, BAD_RESULT},
        '{'{64'd1, 6'd1}, 1'b1, BAD_RESULT},
        '{'{ALL_ONES, 6'd37}, 1'b1, BAD_RESULT},
        '{'{ALL_ONES, 6'd63}, 1'b1, BAD_RESULT},
        '{'{64'd0, 6'd0}, 1'b1, BAD_RESULT},
        '{'{64'd1, 6'd2}, 1'b1, '{ASCII_ZERO + 7'd1, 1'b1, 1'b0}},
        '{'{64'd9, 6'd10}, 1'b1, '{ASCII_ZERO + 7'd9, 1'b1, 1'b0}},
        '{'{64'd10, 6'd11}, 1'b1, '{ASCII_ALPHA + 7'd10, 1'b1, 1'b0}},
        '{'{64'd35, 6'd36}, 1'b1, '{ASCII_ALPHA + 7'd35, 1'b1, 1'b0}},
        '{'{ALL_ONES, 6'd2}, 1'b0, NO_RESULT},
        '{'{64'h8000_0000_0000_0000, 6'd2}, 1'b0, NO_RESULT},
        '{'{ALL_ONES, 6'd36}, 1'b0, NO_RESULT},
        '{'{ALL_ONES, 6'd16}, 1'b0, NO_RESULT},
        '{'{ALL_ONES, 6'd10}, 1'b0, NO_RESULT},
        '{'{64'd36, 6'd36}, 1'b0, NO_RESULT},
        '{'{64'd12345, 6'd10}, 1'b0, NO_RESULT},
        '{'{64'd255, 6'd3}, 1'b0, NO_RESULT},
        '{'{64'hDEAD_BEEF_CAFE_F00D, 6'd7}, 1'b0, NO_RESULT},
        '{'{64'h5555_5555_5555_5555, 6'd35}, 1'b0, NO_RESULT},
        '{'{64'hAAAA_AAAA_AAAA_AAAA, 6'd2}, 1'b0, NO_RESULT}
    };

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    logic      typed_pending;
    out_item_t typed_expected;

    out_item_t pending_digits [$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_cycles_left = 0;

    radix_digit_emitter #(
        .VALUE_BITS(VALUE_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // digits of value in radix, most significant first
    function automatic void convert_to_digits(input logic [VALUE_W-1:0] value,
                                              input logic [RADIX_W-1:0] radix);
        logic [VALUE_W-1:0] rest;
        logic [VALUE_W-1:0] rem;
        logic [CHAR_W-1:0]  chars [$];
        out_item_t          digit;
        rest = value & VALUE_MASK;
        if (radix < RADIX_MIN || radix > RADIX_MAX)
        begin
            pending_digits.push_back(BAD_RESULT);
        end
        else if (rest == '0)
        begin
            pending_digits.push_back(ZERO_RESULT);
        end
        else
        begin
            while (rest != '0)
            begin
                rem = rest % VALUE_W'(radix);
                rest = rest / VALUE_W'(radix);
                if (rem < VALUE_W'(DEC_LIMIT))
                    chars.push_front(ASCII_ZERO + CHAR_W'(rem));
                else
                    chars.push_front(ASCII_ALPHA + CHAR_W'(rem));
            end
            foreach (chars[i])
            begin
                digit.digit_char = chars[i];
                digit.last = (i == chars.size() - 1);
                digit.bad_radix = 1'b0;
                pending_digits.push_back(digit);
            end
        end
    endfunction

    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (typed_pending)
                    pending_digits.push_back(typed_expected);
                else
                    convert_to_digits(in_item.value, in_item.radix);
            end
            if (out_valid && out_ready)
            begin
                if (pending_digits.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digit: char %0d last %0b bad %0b",
                                 out_item.digit_char, out_item.last, out_item.bad_radix);
                end
                else
                begin
                    want = pending_digits.pop_front();
                    if (out_item.digit_char !== want.digit_char ||
                        out_item.last !== want.last ||
                        out_item.bad_radix !== want.bad_radix)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"digit mismatch: expected char %0d last %0b bad %0b,",
                                      " got char %0d last %0b bad %0b"},
                                     want.digit_char, want.last, want.bad_radix,
                                     out_item.digit_char, out_item.last,
                                     out_item.bad_radix);
                    end
                end
            end
        end
    end

    initial
    begin : receiver
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles_left > 0)
            begin
                hold_cycles_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic offer(input in_item_t item, input logic typed, input out_item_t result);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        typed_pending <= typed;
        typed_expected <= result;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_for_digits;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
    endtask

    // quick items are zero, tiny or bad-radix values that the block turns around fast
    task automatic send_random(input int count, input bit quick);
        in_item_t item;
        int       width;
        for (int n = 0; n < count; n++)
        begin
            if (quick)
                width = $urandom_range(4, 0);
            else if ($urandom_range(9) == 0)
                width = VALUE_W;
            else
                width = $urandom_range(40, 0);
            item.value = {$urandom, $urandom};
            if (width < VALUE_W)
                item.value = item.value & ((64'd1 << width) - 64'd1);
            if ($urandom_range(99) < 15)
            begin
                if ($urandom_range(1) == 0)
                    item.radix = RADIX_W'($urandom_range(1, 0));
                else
                    item.radix = RADIX_W'($urandom_range(63, 37));
            end
            else
                item.radix = RADIX_W'($urandom_range(RADIX_MAX, RADIX_MIN));
            offer(item, 1'b0, NO_RESULT);
        end
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        typed_pending = 1'b0;
        typed_expected = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            offer(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
        wait_for_digits();

        send_random(25, 1'b0);

        send_idle_pct = 63;
        send_random(25, 1'b0);

        send_idle_pct = 0;
        recv_stall_pct = 63;
        send_random(25, 1'b0);

        send_idle_pct = 29;
        recv_stall_pct = 29;
        send_random(25, 1'b0);
        wait_for_digits();

        // receiver holds off while items keep coming, so the input must stall
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles_left = 1500;
        send_random(20, 1'b1);
        wait_for_digits();

        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_digits.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/rde_pkg.sv
rtl/rde_ram.sv
rtl/rde_fifo.sv
rtl/rde_front.sv
rtl/rde_back.sv
rtl/radix_digit_emitter.sv
sim/radix_digit_emitter_test.sv
